// ----- hdl/sgrc_pkg.sv -----
// ----------------------------------------------------------------------------
// sgrc_pkg
// Shared types and codes for the scatter-gather read cursor: transaction
// payloads, segment table entry, controller commands and datapath status.
// ----------------------------------------------------------------------------
package sgrc_pkg;

  // transaction modes
  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_FINISH = 3'd1;
  localparam logic [2:0] MODE_READ   = 3'd2;
  localparam logic [2:0] MODE_SEEK   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // segment table read address select
  localparam logic [1:0] RA_J1 = 2'd0;
  localparam logic [1:0] RA_J2 = 2'd1;
  localparam logic [1:0] RA_I  = 2'd2;
  localparam logic [1:0] RA_I1 = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [47:0] position;
    logic [31:0] length;
    logic [47:0] seg_addr;
  } sgrc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] out_addr;
    logic [31:0] read_len;
    logic [31:0] bytes_left;
  } sgrc_out_t;

  typedef struct packed {
    logic [47:0] pos;
    logic [31:0] len;
    logic [47:0] base;
  } sgrc_entry_t;

  // controller to datapath
  typedef struct packed {
    logic       cap;
    logic       push_init;
    logic       i_zero;
    logic       push_shift;
    logic       push_write;
    logic       seek_step;
    logic       seek_load;
    logic       load_seg;
    logic       rem_total;
    logic       read_exec;
    logic       cur_idle;
    logic       clear;
    logic [1:0] rd_sel;
    logic       finish;
    logic [1:0] code;
  } sgrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic ovf;
    logic cnt_zero;
    logic seek_same;
    logic active;
    logic j_zero;
    logic push_gt;
    logic range_out;
    logic scan_lt;
    logic scan_hit;
    logic scan_last;
    logic used_up;
    logic has_next;
    logic req_finish;
  } sgrc_stat_t;

endpackage

// ----- hdl/sgrc_ram.sv -----
// ----------------------------------------------------------------------------
// sgrc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sgrc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sgrc_ctrl.sv -----
// ----------------------------------------------------------------------------
// sgrc_ctrl
// Controller state machine: decodes each transaction and sequences the
// segment table walks for sorted insert, seek and cursor loads.
// ----------------------------------------------------------------------------
module sgrc_ctrl import sgrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] mode,
  input  sgrc_stat_t st,
  output sgrc_cmd_t  cmd,
  output logic       busy
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PUSH_RD   = 4'd1;
  localparam logic [3:0] S_PUSH_CHK  = 4'd2;
  localparam logic [3:0] S_PUSH_WR   = 4'd3;
  localparam logic [3:0] S_SEEK_RD   = 4'd4;
  localparam logic [3:0] S_SEEK_RNG  = 4'd5;
  localparam logic [3:0] S_SEEK_SCAN = 4'd6;
  localparam logic [3:0] S_SEEK_LOAD = 4'd7;
  localparam logic [3:0] S_LOAD_RD   = 4'd8;
  localparam logic [3:0] S_LOAD      = 4'd9;
  localparam logic [3:0] S_READ      = 4'd10;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RA_I;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.cap = 1'b1;
          case (mode)
            MODE_PUSH: begin
              if (st.full || st.ovf) begin
                cmd.finish = 1'b1;
                cmd.code   = ST_FULL;
              end else begin
                cmd.push_init = 1'b1;
                state_next    = S_PUSH_RD;
              end
            end
            MODE_FINISH: begin
              if (st.cnt_zero) begin
                cmd.cur_idle = 1'b1;
                cmd.finish   = 1'b1;
                cmd.code     = ST_EMPTY;
              end else begin
                cmd.i_zero = 1'b1;
                state_next = S_LOAD_RD;
              end
            end
            MODE_READ: begin
              if (st.active) begin
                state_next = S_READ;
              end else begin
                cmd.finish = 1'b1;
                cmd.code   = ST_MISS;
              end
            end
            MODE_SEEK: begin
              if (st.cnt_zero) begin
                cmd.finish = 1'b1;
                cmd.code   = ST_MISS;
              end else if (st.seek_same) begin
                cmd.finish = 1'b1;
                cmd.code   = ST_OK;
              end else begin
                cmd.i_zero = 1'b1;
                state_next = S_SEEK_RD;
              end
            end
            MODE_CLEAR: begin
              cmd.clear  = 1'b1;
              cmd.finish = 1'b1;
              cmd.code   = ST_OK;
            end
            default: begin
              cmd.finish = 1'b1;
              cmd.code   = ST_MISS;
            end
          endcase
        end
      end
      // sorted insert: walk down from the tail, moving larger entries up
      S_PUSH_RD: begin
        cmd.rd_sel = RA_J1;
        state_next = S_PUSH_CHK;
      end
      S_PUSH_CHK: begin
        if (st.j_zero || !st.push_gt) begin
          state_next = S_PUSH_WR;
        end else begin
          cmd.push_shift = 1'b1;
          cmd.rd_sel     = RA_J2;
        end
      end
      S_PUSH_WR: begin
        cmd.push_write = 1'b1;
        cmd.finish     = 1'b1;
        cmd.code       = ST_OK;
        state_next     = S_IDLE;
      end
      // seek: span check against the first segment, then scan in order
      S_SEEK_RD: begin
        state_next = S_SEEK_RNG;
      end
      S_SEEK_RNG: begin
        if (st.range_out) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_MISS;
          state_next = S_IDLE;
        end else begin
          state_next = S_SEEK_SCAN;
        end
      end
      S_SEEK_SCAN: begin
        if (st.scan_lt) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_MISS;
          state_next = S_IDLE;
        end else if (st.scan_hit) begin
          state_next = S_SEEK_LOAD;
        end else if (st.scan_last) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_MISS;
          state_next = S_IDLE;
        end else begin
          cmd.seek_step = 1'b1;
          cmd.rd_sel    = RA_I1;
        end
      end
      S_SEEK_LOAD: begin
        cmd.seek_load = 1'b1;
        cmd.finish    = 1'b1;
        cmd.code      = ST_OK;
        state_next    = S_IDLE;
      end
      // cursor load from the table, for finish and segment advance
      S_LOAD_RD: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_seg  = 1'b1;
        cmd.rem_total = st.req_finish;
        cmd.finish    = 1'b1;
        cmd.code      = ST_OK;
        state_next    = S_IDLE;
      end
      S_READ: begin
        cmd.read_exec = 1'b1;
        if (st.used_up && st.has_next) begin
          state_next = S_LOAD_RD;
        end else begin
          cmd.finish = 1'b1;
          cmd.code   = ST_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/sgrc_datapath.sv -----
// ----------------------------------------------------------------------------
// sgrc_datapath
// Segment table RAM, cursor and byte count registers, the compare and
// arithmetic used by insert, seek and read, and the result register.
// ----------------------------------------------------------------------------
module sgrc_datapath import sgrc_pkg::*; #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  sgrc_in_t   item,
  input  sgrc_cmd_t  cmd,
  output sgrc_stat_t st,
  output sgrc_out_t  result,
  output logic       done
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  // architectural state
  logic [CNT_W-1:0] count;
  logic [31:0]      total;
  logic [31:0]      remaining;
  logic [IDX_W-1:0] cur_index;
  logic             cur_active;
  logic [47:0]      cur_pos;
  logic [31:0]      cur_len;
  logic [47:0]      cur_addr;

  // working registers
  sgrc_in_t         req;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] i;
  logic [31:0]      done_sum;
  logic [31:0]      off;
  logic [1:0]       res_status;
  logic [47:0]      res_addr;
  logic [31:0]      res_len;

  // table port
  logic             we;
  logic [IDX_W-1:0] waddr;
  sgrc_entry_t      wdata;
  logic [IDX_W-1:0] raddr;
  sgrc_entry_t      rd;
  logic [$bits(sgrc_entry_t)-1:0] rdata;

  // combinational terms
  logic [32:0]      sum_total;
  logic [32:0]      rem_push;
  logic [48:0]      span_end;
  logic [47:0]      off_full;
  logic [CNT_W-1:0] i_plus;
  logic [CNT_W-1:0] nx;
  logic [31:0]      grant;
  logic [31:0]      seek_used;

  sgrc_ram #(
    .WIDTH ($bits(sgrc_entry_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd = sgrc_entry_t'(rdata);

  // table write: shift an entry up or place the new one
  assign we    = cmd.push_shift | cmd.push_write;
  assign waddr = j;
  assign wdata = cmd.push_shift ? rd :
                 sgrc_entry_t'{pos: req.position, len: req.length, base: req.seg_addr};

  // table read address
  always_comb begin
    case (cmd.rd_sel)
      RA_J1:   raddr = j - IDX_W'(1);
      RA_J2:   raddr = j - IDX_W'(1) - IDX_W'(1);
      RA_I:    raddr = i;
      RA_I1:   raddr = i + IDX_W'(1);
      default: raddr = i;
    endcase
  end

  // arithmetic and compares
  assign sum_total = {1'b0, total} + {1'b0, req.length};
  assign rem_push  = {1'b0, remaining} + {1'b0, req.length};
  assign span_end  = {1'b0, rd.pos} + {17'd0, total};
  assign off_full  = req.position - rd.pos;
  assign i_plus    = CNT_W'(i) + CNT_W'(1);
  assign nx        = CNT_W'(cur_index) + CNT_W'(1);
  assign grant     = (req.length <= cur_len) ? req.length : cur_len;
  assign seek_used = done_sum + off;

  // status to the controller
  always_comb begin
    st            = '0;
    st.full       = (count == CNT_W'(MAX_SEGMENTS));
    st.ovf        = ({1'b0, total} + {1'b0, item.length}) > 33'h0_FFFF_FFFF;
    st.cnt_zero   = (count == '0);
    st.seek_same  = cur_active && (item.position == cur_pos);
    st.active     = cur_active;
    st.j_zero     = (j == '0);
    st.push_gt    = (rd.pos > req.position);
    st.range_out  = (req.position < rd.pos) || ({1'b0, req.position} >= span_end);
    st.scan_lt    = (req.position < rd.pos);
    st.scan_hit   = !(req.position < rd.pos) && (off_full < {16'd0, rd.len});
    st.scan_last  = (i_plus >= count);
    st.used_up    = (req.length >= cur_len);
    st.has_next   = (nx < count);
    st.req_finish = (req.mode == MODE_FINISH);
  end

  // table bookkeeping and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      total      <= '0;
      remaining  <= '0;
      cur_index  <= '0;
      cur_active <= 1'b0;
      cur_pos    <= '0;
      cur_len    <= '0;
      cur_addr   <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.clear || cmd.cur_idle) begin
        cur_index  <= '0;
        cur_active <= 1'b0;
        cur_pos    <= '0;
        cur_len    <= '0;
        cur_addr   <= '0;
      end
      if (cmd.clear) begin
        count     <= '0;
        total     <= '0;
        remaining <= '0;
      end
      if (cmd.push_write) begin
        count     <= count + CNT_W'(1);
        total     <= sum_total[31:0];
        remaining <= (rem_push > sum_total) ? sum_total[31:0] : rem_push[31:0];
        if (cur_active && (j <= cur_index)) begin
          cur_index <= cur_index + IDX_W'(1);
        end
      end
      if (cmd.seek_load) begin
        cur_active <= 1'b1;
        cur_index  <= i;
        cur_pos    <= req.position;
        cur_len    <= rd.len - off;
        cur_addr   <= rd.base + {16'd0, off};
        remaining  <= total - seek_used;
      end
      if (cmd.load_seg) begin
        cur_active <= 1'b1;
        cur_index  <= i;
        cur_pos    <= rd.pos;
        cur_len    <= rd.len;
        cur_addr   <= rd.base;
        if (cmd.rem_total) begin
          remaining <= total;
        end
      end
      if (cmd.read_exec) begin
        remaining <= (grant >= remaining) ? 32'd0 : remaining - grant;
        if (req.length >= cur_len) begin
          if (!(nx < count)) begin
            cur_index  <= '0;
            cur_active <= 1'b0;
            cur_pos    <= '0;
            cur_len    <= '0;
            cur_addr   <= '0;
          end
        end else begin
          cur_len  <= cur_len - grant;
          cur_addr <= cur_addr + {16'd0, grant};
          cur_pos  <= cur_pos + {16'd0, grant};
        end
      end
    end
  end

  // walk indices, captured request and result payload
  always_ff @(posedge clk) begin
    off <= off_full[31:0];
    if (cmd.cap) begin
      req      <= item;
      res_addr <= '0;
      res_len  <= '0;
    end
    if (cmd.push_init) begin
      j <= count[IDX_W-1:0];
    end
    if (cmd.push_shift) begin
      j <= j - IDX_W'(1);
    end
    if (cmd.i_zero) begin
      i        <= '0;
      done_sum <= '0;
    end
    if (cmd.seek_step) begin
      i        <= i + IDX_W'(1);
      done_sum <= done_sum + rd.len;
    end
    if (cmd.read_exec) begin
      res_addr <= cur_addr;
      res_len  <= grant;
      i        <= nx[IDX_W-1:0];
    end
    if (cmd.finish) begin
      res_status <= cmd.code;
    end
  end

  // result transaction
  assign result.status     = res_status;
  assign result.out_addr   = res_addr;
  assign result.read_len   = res_len;
  assign result.bytes_left = remaining;

endmodule

// ----- hdl/scatter_gather_read_cursor_top.sv -----
// ----------------------------------------------------------------------------
// scatter_gather_read_cursor_top
// Sorted segment table with a read cursor: push, finish, read, seek, clear.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// appears for exactly one cycle with done high, one cycle after the last
// cycle of work, and must be sampled then since the block cannot be stalled.
// Completed at decode: clear, unknown mode, seek to the cursor position and
// every request rejected at decode. A read that steps to the next segment
// loads it from the table; finish loads the first segment. A push walks one
// entry per stored segment with a larger position; a seek ends after the span
// check when the position is outside the covered span, else scans segments in
// order until one holds it or none can. The walks are set by the single
// registered read port of the segment table RAM, one entry a cycle. A new
// transaction can be taken in the cycle that done is high.
// ----------------------------------------------------------------------------
module scatter_gather_read_cursor_top import sgrc_pkg::*; #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  sgrc_in_t  item,
  output logic      done,
  output sgrc_out_t result
);

  sgrc_cmd_t  cmd;
  sgrc_stat_t st;

  sgrc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (item.mode),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  sgrc_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .st     (st),
    .result (result),
    .done   (done)
  );

  // an accepted transaction either completes next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted transaction neither completed nor in progress");

  // a result only follows work on a transaction
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a transaction");

  // a finish on an empty table can only see zero bytes remaining
  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_EMPTY)) |-> (result.bytes_left == 32'd0))
    else $error("empty table reports remaining bytes");

endmodule
